>>> sv/opi_pkg.sv
// Shared types and constants for the OFDM pilot inserter.
// Used by opi_table_mem, opi_seq and ofdm_pilot_inserter; no dependencies.
package opi_pkg;

  // Fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int SLOT_W     = 10;
  localparam int ENTRY_W    = 3;
  localparam int DCOUNT_W   = 10;
  localparam int PCOUNT_W   = 4;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_ADDR_W = 1;

  // Stream packing
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 2;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_DATA_COUNT  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PILOT_COUNT = 1'd1;

  // Input item kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // Register reset values
  localparam logic [DCOUNT_W-1:0] DATA_COUNT_RST  = 10'd48;
  localparam logic [PCOUNT_W-1:0] PILOT_COUNT_RST = 4'd4;

  // One pilot table entry
  typedef struct packed {
    logic        [SLOT_W-1:0]   slot;
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
  } pilot_entry_t;

  // Table write request
  typedef struct packed {
    logic               en;
    logic [ENTRY_W-1:0] entry;
    pilot_entry_t       data;
  } tbl_wr_t;

endpackage

>>> sv/ofdm_pilot_inserter.sv
// OFDM pilot inserter top level: configuration registers, table load path,
// pilot table memory and symbol sequencer. Depends on opi_pkg, opi_table_mem, opi_seq.
//
// Merges a stream of complex Q1.15 data subcarriers with up to MAX_PILOTS
// pilots held in an on-chip table. A load item (tuser = 1) writes one table
// entry; its output slot is pilot_index + (data_count + pilot_count clamped to
// MAX_PILOTS)/2 modulo 1024, computed at load time, so load the table after
// setting the registers and in ascending slot order. A data item (tuser = 0)
// yields 1 + P results, where P is the number of pilots emitted with it (those
// due before it, plus the trailing pilots on the last item of a symbol): once
// accepted, it gets one result per cycle from the sequencer while the output
// does not stall; the sequencer reads the table memory at its pointer every
// cycle and accepts the next item once the item's last result is in the output
// register; output stalls hold it. Configuration writes belong in idle periods.
module ofdm_pilot_inserter #(
  parameter int MAX_PILOTS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // s_tdata from bit 0: sample_re[16], sample_im[16], entry[3],
  //   pilot_index[10], pilot_re[16], pilot_im[16], zero pad[3]
  input  logic [opi_pkg::IN_TDATA_W-1:0]       s_tdata,
  // s_tuser: kind[1]
  input  logic [0:0]                           s_tuser,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // m_tdata from bit 0: out_re[16], out_im[16]
  output logic [opi_pkg::OUT_TDATA_W-1:0]      m_tdata,
  // m_tuser from bit 0: is_pilot[1], run_last[1]
  output logic [opi_pkg::OUT_TUSER_W-1:0]      m_tuser,
  // m_tlast: symbol_end
  output logic                                 m_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [opi_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [opi_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int AW    = (MAX_PILOTS > 1) ? $clog2(MAX_PILOTS) : 1;
  localparam int CNT_W = $clog2(MAX_PILOTS + 1);
  localparam int PCW   = CNT_W + opi_pkg::PCOUNT_W;
  localparam int SUM_W = opi_pkg::DCOUNT_W + 1;

  logic [opi_pkg::DCOUNT_W-1:0]        data_count;
  logic [opi_pkg::PCOUNT_W-1:0]        pilot_count;
  logic [CNT_W-1:0]                    pc;
  logic [SUM_W-1:0]                    sym_len;
  logic [opi_pkg::SLOT_W-1:0]          half;

  logic                                kind;
  logic signed [opi_pkg::SAMPLE_W-1:0] sample_re, sample_im;
  logic [opi_pkg::ENTRY_W-1:0]         entry;
  logic [opi_pkg::SLOT_W-1:0]          pilot_index;
  logic signed [opi_pkg::SAMPLE_W-1:0] pilot_re, pilot_im;

  opi_pkg::tbl_wr_t                    tbl_wr;
  logic [AW-1:0]                       rd_addr;
  opi_pkg::pilot_entry_t               rd_data;

  logic signed [opi_pkg::SAMPLE_W-1:0] out_re, out_im;
  logic                                out_pilot, out_end, out_last;

  // Input unpacking
  assign kind        = s_tuser[0];
  assign sample_re   = s_tdata[15:0];
  assign sample_im   = s_tdata[31:16];
  assign entry       = s_tdata[34:32];
  assign pilot_index = s_tdata[44:35];
  assign pilot_re    = s_tdata[60:45];
  assign pilot_im    = s_tdata[76:61];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      data_count  <= opi_pkg::DATA_COUNT_RST;
      pilot_count <= opi_pkg::PILOT_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        opi_pkg::REG_DATA_COUNT:  data_count  <= cfg_data;
        opi_pkg::REG_PILOT_COUNT: pilot_count <= cfg_data[opi_pkg::PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pilots in use, clamped to the table depth
  assign pc = (PCW'(pilot_count) > PCW'(MAX_PILOTS)) ? CNT_W'(MAX_PILOTS)
                                                    : CNT_W'(pilot_count);

  // Slot of a loaded pilot: index plus half the symbol length, mod 1024
  assign sym_len = SUM_W'(data_count) + SUM_W'(pc);
  assign half    = sym_len[SUM_W-1:1];

  always_comb begin
    tbl_wr.en      = s_tvalid && s_tready && (kind == opi_pkg::KIND_LOAD) &&
                     (int'(entry) < MAX_PILOTS);
    tbl_wr.entry   = entry;
    tbl_wr.data.slot = pilot_index + half;
    tbl_wr.data.re = pilot_re;
    tbl_wr.data.im = pilot_im;
  end

  opi_table_mem #(
    .DEPTH (MAX_PILOTS),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  opi_seq #(
    .MAX_PILOTS (MAX_PILOTS),
    .CNT_W      (CNT_W),
    .AW         (AW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_kind    (kind),
    .in_re      (sample_re),
    .in_im      (sample_im),
    .data_count (data_count),
    .pc         (pc),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_re     (out_re),
    .out_im     (out_im),
    .out_pilot  (out_pilot),
    .out_end    (out_end),
    .out_last   (out_last)
  );

  // Output packing
  assign m_tdata = {out_im, out_re};
  assign m_tuser = {out_last, out_pilot};
  assign m_tlast = out_end;

endmodule

>>> sv/opi_table_mem.sv
// Pilot table: synchronous memory, one write port, one registered read port.
// Depends on opi_pkg for the entry and write request types.
module opi_table_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic                  clk,
  input  opi_pkg::tbl_wr_t      wr,
  input  logic [AW-1:0]         rd_addr,
  output opi_pkg::pilot_entry_t rd_data
);

  opi_pkg::pilot_entry_t mem [DEPTH];
  logic [AW-1:0]         wr_addr;

  assign wr_addr = AW'(wr.entry);

  // Write, and read with new data forwarded on an address match
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    if (wr.en && (wr_addr == rd_addr)) begin
      rd_data <= wr.data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/opi_seq.sv
// Symbol sequencer: walks the pilot table, merges pilots with data samples
// and drives the output register. Depends on opi_pkg.
module opi_seq #(
  parameter int MAX_PILOTS = 8,
  parameter int CNT_W      = 4,
  parameter int AW         = 3
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // request in
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_kind,
  input  logic signed [opi_pkg::SAMPLE_W-1:0]   in_re,
  input  logic signed [opi_pkg::SAMPLE_W-1:0]   in_im,
  // configuration
  input  logic        [opi_pkg::DCOUNT_W-1:0]   data_count,
  input  logic        [CNT_W-1:0]               pc,
  // table read
  output logic        [AW-1:0]                  rd_addr,
  input  opi_pkg::pilot_entry_t                 rd_data,
  // request out
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [opi_pkg::SAMPLE_W-1:0]   out_re,
  output logic signed [opi_pkg::SAMPLE_W-1:0]   out_im,
  output logic                                  out_pilot,
  output logic                                  out_end,
  output logic                                  out_last
);

  typedef enum logic [1:0] {S_IDLE, S_PRE, S_TRAIL} state_t;

  state_t                               state, state_next;
  logic [CNT_W-1:0]                     next_pilot, next_pilot_next;
  logic [opi_pkg::SLOT_W-1:0]           output_slot, output_slot_next;
  logic [opi_pkg::DCOUNT_W-1:0]         data_seen, data_seen_next;
  logic signed [opi_pkg::SAMPLE_W-1:0]  samp_re, samp_re_next;
  logic signed [opi_pkg::SAMPLE_W-1:0]  samp_im, samp_im_next;
  logic                                 out_valid_next;
  logic signed [opi_pkg::SAMPLE_W-1:0]  out_re_next, out_im_next;
  logic                                 out_pilot_next, out_end_next, out_last_next;

  logic                                 can_emit;
  logic                                 have_pilot;
  logic                                 pilot_due;
  logic [opi_pkg::DCOUNT_W-1:0]         ds_inc;
  logic                                 sym_last;
  logic [CNT_W-1:0]                     np_inc;
  logic                                 trail_done;

  assign in_ready   = (state == S_IDLE);
  assign can_emit   = !out_valid || out_ready;
  assign have_pilot = (next_pilot < pc);
  assign pilot_due  = have_pilot && (rd_data.slot <= output_slot);
  assign ds_inc     = data_seen + 1'b1;
  assign sym_last   = (data_count == '0) || (ds_inc >= data_count);
  assign np_inc     = next_pilot + 1'b1;
  assign trail_done = (np_inc >= pc);

  // Table is read at the pointer's next value so rd_data tracks next_pilot
  assign rd_addr = (next_pilot_next < CNT_W'(MAX_PILOTS)) ? AW'(next_pilot_next) : '0;

  // Next-state logic
  always_comb begin
    state_next       = state;
    next_pilot_next  = next_pilot;
    output_slot_next = output_slot;
    data_seen_next   = data_seen;
    samp_re_next     = samp_re;
    samp_im_next     = samp_im;
    out_valid_next   = out_valid && !out_ready;
    out_re_next      = out_re;
    out_im_next      = out_im;
    out_pilot_next   = out_pilot;
    out_end_next     = out_end;
    out_last_next    = out_last;
    case (state)
      S_IDLE: begin
        if (in_valid && (in_kind == opi_pkg::KIND_DATA)) begin
          samp_re_next = in_re;
          samp_im_next = in_im;
          state_next   = S_PRE;
        end
      end
      S_PRE: begin
        if (can_emit) begin
          out_valid_next = 1'b1;
          if (pilot_due) begin
            // pilot due at or before the current slot
            out_re_next      = rd_data.re;
            out_im_next      = rd_data.im;
            out_pilot_next   = 1'b1;
            out_end_next     = 1'b0;
            out_last_next    = 1'b0;
            next_pilot_next  = np_inc;
            output_slot_next = output_slot + 1'b1;
          end else begin
            out_re_next      = samp_re;
            out_im_next      = samp_im;
            out_pilot_next   = 1'b0;
            output_slot_next = output_slot + 1'b1;
            data_seen_next   = ds_inc;
            if (sym_last && have_pilot) begin
              // trailing pilots follow
              out_end_next  = 1'b0;
              out_last_next = 1'b0;
              state_next    = S_TRAIL;
            end else if (sym_last) begin
              out_end_next     = 1'b1;
              out_last_next    = 1'b1;
              next_pilot_next  = '0;
              output_slot_next = '0;
              data_seen_next   = '0;
              state_next       = S_IDLE;
            end else begin
              out_end_next  = 1'b0;
              out_last_next = 1'b1;
              state_next    = S_IDLE;
            end
          end
        end
      end
      S_TRAIL: begin
        if (can_emit) begin
          out_valid_next = 1'b1;
          out_re_next    = rd_data.re;
          out_im_next    = rd_data.im;
          out_pilot_next = 1'b1;
          if (trail_done) begin
            out_end_next     = 1'b1;
            out_last_next    = 1'b1;
            next_pilot_next  = '0;
            output_slot_next = '0;
            data_seen_next   = '0;
            state_next       = S_IDLE;
          end else begin
            out_end_next    = 1'b0;
            out_last_next   = 1'b0;
            next_pilot_next = np_inc;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      next_pilot  <= '0;
      output_slot <= '0;
      data_seen   <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      next_pilot  <= next_pilot_next;
      output_slot <= output_slot_next;
      data_seen   <= data_seen_next;
      out_valid   <= out_valid_next;
    end
    samp_re   <= samp_re_next;
    samp_im   <= samp_im_next;
    out_re    <= out_re_next;
    out_im    <= out_im_next;
    out_pilot <= out_pilot_next;
    out_end   <= out_end_next;
    out_last  <= out_last_next;
  end

  // Symbol end clears the position counters
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && can_emit && out_end_next) |=>
      (next_pilot == '0 && output_slot == '0 && data_seen == '0))
    else $error("counters not cleared after symbol end");

  // A symbol end is always the last result of its item
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_end) |-> out_last)
    else $error("symbol end without run_last");

  // Trailing phase only runs with a pilot left to emit
  a_trail_pilot: assert property (@(posedge clk) disable iff (rst)
    (state == S_TRAIL) |-> (next_pilot < pc))
    else $error("trailing phase past the last pilot");

  // Pointer never runs beyond the table
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    next_pilot <= CNT_W'(MAX_PILOTS))
    else $error("pilot pointer out of range");

endmodule

>>> test/ofdm_pilot_inserter_test.sv
`timescale 1ns / 1ps
// Self-checking bench for ofdm_pilot_inserter: directed and random symbol traffic,
// checked against a behavioral model of pilot merging. Depends on opi_pkg and the DUT.
module ofdm_pilot_inserter_test;

  localparam int unsigned TABLE_DEPTH  = 8;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  // One input request, unpacked by field
  typedef struct {
    logic        kind;
    logic [15:0] sample_re;
    logic [15:0] sample_im;
    logic [2:0]  entry;
    logic [9:0]  pilot_index;
    logic [15:0] pilot_re;
    logic [15:0] pilot_im;
  } request_t;

  // One output subcarrier
  typedef struct {
    logic [15:0] re;
    logic [15:0] im;
    logic        is_pilot;
    logic        symbol_end;
    logic        run_last;
  } subcarrier_t;

  logic                            clk;
  logic                            rst;
  logic [opi_pkg::IN_TDATA_W-1:0]  s_tdata;
  logic [0:0]                      s_tuser;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [opi_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic [opi_pkg::OUT_TUSER_W-1:0] m_tuser;
  logic                            m_tlast;
  logic                            m_tvalid;
  logic                            m_tready;
  logic                            cfg_we;
  logic [opi_pkg::CFG_ADDR_W-1:0]  cfg_addr;
  logic [opi_pkg::CFG_DATA_W-1:0]  cfg_data;

  // Pilot merge model state
  logic [9:0]  tbl_slot [TABLE_DEPTH];
  logic [15:0] tbl_re [TABLE_DEPTH];
  logic [15:0] tbl_im [TABLE_DEPTH];
  logic [9:0]  sym_slot;
  logic [9:0]  sym_data_seen;
  int unsigned sym_next_pilot;
  int unsigned dc_reg;
  int unsigned pc_reg;

  subcarrier_t expected_subcarriers[$];

  // Bookkeeping and traffic knobs
  int unsigned failures;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned loads_sent;
  int unsigned results_checked;
  int unsigned pilots_checked;
  int unsigned symbols_checked;
  int unsigned sender_idle_pct;
  int unsigned sink_idle_pct;
  logic        hold_pending;

  ofdm_pilot_inserter #(
    .MAX_PILOTS(TABLE_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Work out the subcarriers one accepted request produces
  function void predict_subcarriers(input request_t rq);
    subcarrier_t batch [TABLE_DEPTH + 1];
    int unsigned used;
    int unsigned n;
    int unsigned i;
    logic [9:0]  half;
    used = (pc_reg > TABLE_DEPTH) ? TABLE_DEPTH : pc_reg;
    n = 0;
    if (rq.kind == opi_pkg::KIND_LOAD) begin
      // slot fixed at load time, modulo 1024
      half = 10'((dc_reg + used) / 2);
      tbl_slot[rq.entry] = rq.pilot_index + half;
      tbl_re[rq.entry] = rq.pilot_re;
      tbl_im[rq.entry] = rq.pilot_im;
      return;
    end
    // pilots due at or before the current slot
    while (sym_next_pilot < used && tbl_slot[sym_next_pilot] <= sym_slot) begin
      batch[n] = '{tbl_re[sym_next_pilot], tbl_im[sym_next_pilot], 1'b1, 1'b0, 1'b0};
      n++;
      sym_next_pilot++;
      sym_slot++;
    end
    batch[n] = '{rq.sample_re, rq.sample_im, 1'b0, 1'b0, 1'b0};
    n++;
    sym_slot++;
    sym_data_seen++;
    // last data sample flushes the trailing pilots
    if (dc_reg == 0 || sym_data_seen >= dc_reg) begin
      while (sym_next_pilot < used) begin
        batch[n] = '{tbl_re[sym_next_pilot], tbl_im[sym_next_pilot], 1'b1, 1'b0, 1'b0};
        n++;
        sym_next_pilot++;
      end
      batch[n-1].symbol_end = 1'b1;
      sym_slot = '0;
      sym_data_seen = '0;
      sym_next_pilot = 0;
    end
    batch[n-1].run_last = 1'b1;
    for (i = 0; i < n; i++) begin
      expected_subcarriers.insert(expected_subcarriers.size(), batch[i]);
    end
  endfunction

  function automatic request_t random_request(input logic kind);
    request_t rq;
    rq.kind = kind;
    rq.sample_re = 16'($urandom);
    rq.sample_im = 16'($urandom);
    rq.entry = 3'($urandom);
    rq.pilot_index = 10'($urandom);
    rq.pilot_re = 16'($urandom);
    rq.pilot_im = 16'($urandom);
    return rq;
  endfunction

  // Offer one request, wait for the handshake, then maybe idle
  task send_request(input request_t rq);
    int unsigned gap;
    s_tdata <= {3'b000, rq.pilot_im, rq.pilot_re, rq.pilot_index, rq.entry,
                rq.sample_im, rq.sample_re};
    s_tuser <= rq.kind;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_subcarriers(rq);
    items_sent++;
    if (rq.kind == opi_pkg::KIND_LOAD) loads_sent++;
    gap = ($urandom_range(0, 99) < sender_idle_pct) ? gap_len() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task load_entry(input logic [2:0] entry, input int idx, input logic [15:0] re,
                  input logic [15:0] im);
    request_t rq;
    rq = random_request(opi_pkg::KIND_LOAD);
    rq.entry = entry;
    rq.pilot_index = 10'(idx);
    rq.pilot_re = re;
    rq.pilot_im = im;
    send_request(rq);
  endtask

  task send_data(input logic [15:0] re, input logic [15:0] im);
    request_t rq;
    rq = random_request(opi_pkg::KIND_DATA);
    rq.sample_re = re;
    rq.sample_im = im;
    send_request(rq);
  endtask

  // Drain everything in flight, then let the pipeline go quiet
  task settle();
    s_tvalid <= 1'b0;
    while (expected_subcarriers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Both registers are written back to back while the block is idle
  task set_registers(input int unsigned dc, input int unsigned pc);
    settle();
    cfg_we <= 1'b1;
    cfg_addr <= opi_pkg::REG_DATA_COUNT;
    cfg_data <= dc[opi_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_addr <= opi_pkg::REG_PILOT_COUNT;
    cfg_data <= pc[opi_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    dc_reg = dc & 10'h3FF;
    pc_reg = pc & 4'hF;
  endtask

  // Full symbol: pilot at slot 0, adjacent pilots, last-slot pilot, sample extremes
  task test_directed_symbol();
    sender_idle_pct = 20;
    sink_idle_pct <= 20;
    set_registers(6, 4);
    load_entry(3'd0, -5, 16'h8000, 16'h7FFF);
    load_entry(3'd1, -4, 16'h7FFF, 16'h8000);
    load_entry(3'd2, 0, 16'h0000, 16'h0000);
    load_entry(3'd3, 4, 16'hFFFF, 16'h0001);
    send_data(16'h8000, 16'h8000);
    send_data(16'h7FFF, 16'h7FFF);
    send_data(16'h0000, 16'hFFFF);
    send_data(16'hFFFF, 16'h0000);
    send_data(16'h8000, 16'h7FFF);
    send_data(16'h0001, 16'hFFFE);
  endtask

  // Out-of-order table: a late pilot and one whose slot lies past the symbol
  task test_late_and_beyond();
    set_registers(5, 3);
    load_entry(3'd0, 0, 16'h1234, 16'hEDCB);
    load_entry(3'd1, -2, 16'h5555, 16'hAAAA);
    load_entry(3'd2, 511, 16'hAAAA, 16'h5555);
    repeat (5) send_data(16'($urandom), 16'($urandom));
  endtask

  // No pilots, pilot count above table size, zero data count
  task test_count_extremes();
    set_registers(1, 0);
    repeat (2) send_data(16'($urandom), 16'($urandom));
    set_registers(2, 12);
    load_entry(3'd0, -5, 16'h7FFF, 16'h7FFF);
    load_entry(3'd1, -512, 16'h8000, 16'h8000);
    load_entry(3'd2, -4, 16'h0001, 16'hFFFF);
    load_entry(3'd3, -3, 16'hFFFF, 16'h0001);
    load_entry(3'd4, 0, 16'h00FF, 16'hFF00);
    load_entry(3'd5, 100, 16'h0F0F, 16'hF0F0);
    load_entry(3'd6, 300, 16'h3333, 16'hCCCC);
    load_entry(3'd7, 511, 16'hCCCC, 16'h3333);
    repeat (2) send_data(16'($urandom), 16'($urandom));
    set_registers(0, 1);
    repeat (2) send_data(16'($urandom), 16'($urandom));
  endtask

  // Largest symbol with slot wrap, then data count cut below data already seen
  task test_register_change_mid_symbol();
    set_registers(1023, 8);
    load_entry(3'd0, -512, 16'h8000, 16'h7FFF);
    load_entry(3'd1, -511, 16'h7FFF, 16'h8000);
    load_entry(3'd2, -100, 16'h1111, 16'h2222);
    load_entry(3'd3, 0, 16'h3333, 16'h4444);
    load_entry(3'd4, 100, 16'h5555, 16'h6666);
    load_entry(3'd5, 300, 16'h7777, 16'h8888);
    load_entry(3'd6, 508, 16'h9999, 16'hAAAA);
    load_entry(3'd7, 511, 16'hBBBB, 16'hCCCC);
    repeat (6) send_data(16'($urandom), 16'($urandom));
    set_registers(4, 8);
    send_data(16'($urandom), 16'($urandom));
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task test_backpressure();
    set_registers(5, 2);
    load_entry(3'd0, -3, 16'($urandom), 16'($urandom));
    load_entry(3'd1, 1, 16'($urandom), 16'($urandom));
    sender_idle_pct = 0;
    sink_idle_pct <= 0;
    hold_pending <= 1'b1;
    repeat (20) send_data(16'($urandom), 16'($urandom));
  endtask

  // Random phases: mostly tidy tables and whole symbols, some noise
  task test_random_traffic(input int unsigned count);
    int unsigned start;
    int unsigned dc;
    int unsigned pc;
    int unsigned used;
    int unsigned span;
    int unsigned half;
    int unsigned need;
    int unsigned k;
    int unsigned s;
    int unsigned ndata;
    int unsigned i;
    int unsigned slot_pick [TABLE_DEPTH];
    int unsigned pct_choice [3];
    bit          tidy;
    request_t    rq;
    start = items_sent;
    pct_choice = '{0, 10, 35};
    while (items_sent - start < count) begin
      dc = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
      pc = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(0, 15);
      set_registers(dc, pc);
      sender_idle_pct = pct_choice[$urandom_range(0, 2)];
      sink_idle_pct <= pct_choice[$urandom_range(0, 2)];
      used = (pc > TABLE_DEPTH) ? TABLE_DEPTH : pc;
      span = dc + used;
      half = span / 2;
      tidy = $urandom_range(0, 99) < 80;
      // pick distinct slots in ascending order
      need = used;
      k = 0;
      for (s = 0; s < span && need != 0; s++) begin
        if ($urandom_range(0, span - s - 1) < need) begin
          slot_pick[k] = s;
          k++;
          need--;
        end
      end
      for (k = 0; k < used; k++) begin
        rq = random_request(opi_pkg::KIND_LOAD);
        rq.entry = 3'(k);
        if (tidy) rq.pilot_index = 10'(int'(slot_pick[k]) - int'(half));
        send_request(rq);
      end
      if (tidy) ndata = ((dc > 12) ? 1 : $urandom_range(1, 3)) * dc;
      else ndata = $urandom_range(1, 2 * dc + 1);
      for (i = 0; i < ndata; i++) begin
        if (!tidy && $urandom_range(0, 99) < 8) begin
          send_request(random_request(opi_pkg::KIND_LOAD));
        end
        send_request(random_request(opi_pkg::KIND_DATA));
      end
    end
  endtask

  function void check_field(input string name, input logic [15:0] want,
                            input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      failures++;
    end
  endfunction

  // Compare every accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    subcarrier_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_checked++;
      if (m_tuser[0]) pilots_checked++;
      if (m_tlast) symbols_checked++;
      if (expected_subcarriers.size() == 0) begin
        $error("result with nothing pending: re 'h%0h im 'h%0h", m_tdata[15:0],
               m_tdata[31:16]);
        failures++;
      end else begin
        want = expected_subcarriers.pop_front();
        check_field("out_re", want.re, m_tdata[15:0]);
        check_field("out_im", want.im, m_tdata[31:16]);
        check_field("is_pilot", 16'(want.is_pilot), 16'(m_tuser[0]));
        check_field("run_last", 16'(want.run_last), 16'(m_tuser[1]));
        check_field("symbol_end", 16'(want.symbol_end), 16'(m_tlast));
      end
    end
  end

  // Receiver: random stalls plus the long hold-off on request
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending <= 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_left != 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < sink_idle_pct) begin
        m_tready <= 1'b0;
        stall_left = gap_len() - 1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ofdm_pilot_inserter verification failed");
    $finish;
  end

  initial begin : run_tests
    rst <= 1'b1;
    s_tdata <= '0;
    s_tuser <= opi_pkg::KIND_DATA;
    s_tvalid <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= opi_pkg::REG_DATA_COUNT;
    cfg_data <= '0;
    hold_pending <= 1'b0;
    sink_idle_pct <= 0;
    sender_idle_pct = 0;
    failures = 0;
    items_sent = 0;
    loads_sent = 0;
    results_checked = 0;
    pilots_checked = 0;
    symbols_checked = 0;
    dc_reg = opi_pkg::DATA_COUNT_RST;
    pc_reg = opi_pkg::PILOT_COUNT_RST;
    sym_slot = '0;
    sym_data_seen = '0;
    sym_next_pilot = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed_symbol();
    test_late_and_beyond();
    test_count_extremes();
    test_register_change_mid_symbol();
    test_backpressure();
    test_random_traffic(300);

    settle();
    $display("Sent %0d requests (%0d table loads); checked %0d subcarriers, %0d pilots,",
             items_sent, loads_sent, results_checked, pilots_checked);
    $display("%0d symbols, across pilot counts 0..15 and data counts 0..1023",
             symbols_checked);
    if (failures == 0) begin
      $display("ofdm_pilot_inserter verification clean");
    end else begin
      $display("ofdm_pilot_inserter verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/opi_pkg.sv
sv/opi_table_mem.sv
sv/opi_seq.sv
sv/ofdm_pilot_inserter.sv
test/ofdm_pilot_inserter_test.sv
